/* design/rgbhsv_pkg.sv */
// Shared types and constants of the RGB to HSV pixel converter.
`timescale 1ns / 1ps
`default_nettype none

package rgbhsv_pkg;

    // Channel and quotient widths
    localparam int PIX_W   = 8;
    localparam int QUOT_W  = 8;
    localparam int DIFF_W  = 9;
    localparam int DRAW_W  = 19;
    localparam int DEG_W   = 17;
    localparam int HNUM_W  = 24;
    localparam int HDEN_W  = 16;
    localparam int SNUM_W  = 16;

    // Hue offsets and scale factors (hue out = deg * 177 / 250)
    localparam logic [7:0] DEG_60        = 8'd60;
    localparam logic [7:0] DEG_120       = 8'd120;
    localparam logic [7:0] DEG_240       = 8'd240;
    localparam logic [8:0] DEG_360       = 9'd360;
    localparam logic [7:0] HUE_SCALE_NUM = 8'd177;
    localparam logic [7:0] HUE_SCALE_DEN = 8'd250;
    localparam logic [7:0] SAT_FULL      = 8'd255;

    // Which channel holds the maximum
    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } max_sel_t;

    // Work item handed from the front end to the divider
    typedef struct packed {
        logic [HNUM_W-1:0] hue_rem;
        logic [HDEN_W-1:0] hue_den;
        logic [SNUM_W-1:0] sat_rem;
        logic [PIX_W-1:0]  sat_den;
        logic [PIX_W-1:0]  brightness;
    } div_work_t;

endpackage

`default_nettype wire

/* design/rgbhsv_front.sv */
// Front end: max/min/delta, hue numerator in degrees times delta, division operands.
`timescale 1ns / 1ps
`default_nettype none

module rgbhsv_front (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [7:0]              in_blue,
    input  wire logic [7:0]              in_green,
    input  wire logic [7:0]              in_red,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output rgbhsv_pkg::div_work_t        out_work
);

    // Stage A: channel max, delta, selector, signed channel difference
    logic                                  a_valid_reg;
    logic [rgbhsv_pkg::PIX_W-1:0]          a_max_reg;
    logic [rgbhsv_pkg::PIX_W-1:0]          a_delta_reg;
    rgbhsv_pkg::max_sel_t                  a_sel_reg;
    logic signed [rgbhsv_pkg::DIFF_W-1:0]  a_diff_reg;

    // Stage B: non-negative degrees times delta
    logic                                  b_valid_reg;
    logic [rgbhsv_pkg::PIX_W-1:0]          b_max_reg;
    logic [rgbhsv_pkg::PIX_W-1:0]          b_delta_reg;
    logic [rgbhsv_pkg::DEG_W-1:0]          b_deg_reg;

    // Stage C: divider operands
    logic                                  c_valid_reg;
    rgbhsv_pkg::div_work_t                 c_work_reg;

    logic ready_a;
    logic ready_b;
    logic ready_c;

    // Per-stage ready: a stage takes new data when empty or when it drains
    assign ready_c  = !c_valid_reg || out_ready;
    assign ready_b  = !b_valid_reg || ready_c;
    assign ready_a  = !a_valid_reg || ready_b;
    assign in_ready = ready_a;

    // Stage A logic; ties go to red, then green
    logic [rgbhsv_pkg::PIX_W-1:0]          a_max_next;
    logic [rgbhsv_pkg::PIX_W-1:0]          a_min;
    logic [rgbhsv_pkg::PIX_W-1:0]          a_delta_next;
    rgbhsv_pkg::max_sel_t                  a_sel_next;
    logic signed [rgbhsv_pkg::DIFF_W-1:0]  a_diff_next;

    always_comb begin
        a_max_next = in_red;
        if (in_green > a_max_next) a_max_next = in_green;
        if (in_blue > a_max_next) a_max_next = in_blue;
        a_min = in_red;
        if (in_green < a_min) a_min = in_green;
        if (in_blue < a_min) a_min = in_blue;
        a_delta_next = a_max_next - a_min;
        if (a_max_next == in_red) begin
            a_sel_next  = rgbhsv_pkg::SEL_RED;
            a_diff_next = $signed({1'b0, in_green}) - $signed({1'b0, in_blue});
        end else if (a_max_next == in_green) begin
            a_sel_next  = rgbhsv_pkg::SEL_GREEN;
            a_diff_next = $signed({1'b0, in_blue}) - $signed({1'b0, in_red});
        end else begin
            a_sel_next  = rgbhsv_pkg::SEL_BLUE;
            a_diff_next = $signed({1'b0, in_red}) - $signed({1'b0, in_green});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (ready_a) begin
            a_valid_reg <= in_valid;
        end
        if (ready_a && in_valid) begin
            a_max_reg   <= a_max_next;
            a_delta_reg <= a_delta_next;
            a_sel_reg   <= a_sel_next;
            a_diff_reg  <= a_diff_next;
        end
    end

    // Sign extension of the channel difference
    function automatic logic signed [rgbhsv_pkg::DRAW_W-1:0] DRAW_EXT(
        input logic signed [rgbhsv_pkg::DIFF_W-1:0] val
    );
        DRAW_EXT = {{(rgbhsv_pkg::DRAW_W-rgbhsv_pkg::DIFF_W){val[rgbhsv_pkg::DIFF_W-1]}}, val};
    endfunction

    // Stage B logic: deg*delta = 60*diff + offset*delta, wrapped when negative
    logic [15:0]                          b_offset_term;
    logic [rgbhsv_pkg::DEG_W-1:0]         b_full_term;
    logic signed [rgbhsv_pkg::DRAW_W-1:0] b_raw;
    logic signed [rgbhsv_pkg::DRAW_W-1:0] b_wrapped;
    logic [rgbhsv_pkg::DEG_W-1:0]         b_deg_next;

    always_comb begin
        case (a_sel_reg)
            rgbhsv_pkg::SEL_GREEN: b_offset_term = {8'b0, a_delta_reg} *
                                                   {8'b0, rgbhsv_pkg::DEG_120};
            rgbhsv_pkg::SEL_BLUE:  b_offset_term = {8'b0, a_delta_reg} *
                                                   {8'b0, rgbhsv_pkg::DEG_240};
            default:               b_offset_term = 16'd0;
        endcase
        b_full_term = {9'b0, a_delta_reg} * {8'b0, rgbhsv_pkg::DEG_360};
        b_raw = DRAW_EXT(a_diff_reg) * $signed({11'b0, rgbhsv_pkg::DEG_60}) +
                $signed({3'b0, b_offset_term});
        b_wrapped = b_raw + $signed({2'b0, b_full_term});
        if (b_raw[rgbhsv_pkg::DRAW_W-1]) begin
            b_deg_next = b_wrapped[rgbhsv_pkg::DEG_W-1:0];
        end else begin
            b_deg_next = b_raw[rgbhsv_pkg::DEG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (ready_b) begin
            b_valid_reg <= a_valid_reg;
        end
        if (ready_b && a_valid_reg) begin
            b_max_reg   <= a_max_reg;
            b_delta_reg <= a_delta_reg;
            b_deg_reg   <= b_deg_next;
        end
    end

    // Stage C logic: numerators and divisors; a zero divisor becomes one
    // (its numerator is zero then, so the quotient comes out zero)
    rgbhsv_pkg::div_work_t c_work_next;

    always_comb begin
        c_work_next.hue_rem = {7'b0, b_deg_reg} * {16'b0, rgbhsv_pkg::HUE_SCALE_NUM};
        if (b_delta_reg == 8'd0) begin
            c_work_next.hue_den = 16'd1;
        end else begin
            c_work_next.hue_den = {8'b0, b_delta_reg} * {8'b0, rgbhsv_pkg::HUE_SCALE_DEN};
        end
        c_work_next.sat_rem = {8'b0, b_delta_reg} * {8'b0, rgbhsv_pkg::SAT_FULL};
        if (b_max_reg == 8'd0) begin
            c_work_next.sat_den = 8'd1;
        end else begin
            c_work_next.sat_den = b_max_reg;
        end
        c_work_next.brightness = b_max_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (ready_c) begin
            c_valid_reg <= b_valid_reg;
        end
        if (ready_c && b_valid_reg) begin
            c_work_reg <= c_work_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_work  = c_work_reg;

endmodule

`default_nettype wire

/* design/rgbhsv_div.sv */
// Pipelined restoring divider: one hue and one saturation quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module rgbhsv_div (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire rgbhsv_pkg::div_work_t             in_work,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [rgbhsv_pkg::QUOT_W-1:0]          out_hue,
    output logic [rgbhsv_pkg::QUOT_W-1:0]          out_saturation,
    output logic [rgbhsv_pkg::PIX_W-1:0]           out_brightness
);

    localparam int NSTG = rgbhsv_pkg::QUOT_W;

    logic                                  valid_reg [NSTG];
    rgbhsv_pkg::div_work_t                 work_reg  [NSTG];
    logic [rgbhsv_pkg::QUOT_W-1:0]         hq_reg    [NSTG];
    logic [rgbhsv_pkg::QUOT_W-1:0]         sq_reg    [NSTG];
    logic                                  stage_ready [NSTG];

    genvar k;
    generate
        for (k = 0; k < NSTG; k++) begin : g_stage
            localparam int SH = NSTG - 1 - k;

            logic                              src_valid;
            rgbhsv_pkg::div_work_t             src_work;
            logic [rgbhsv_pkg::QUOT_W-1:0]     src_hq;
            logic [rgbhsv_pkg::QUOT_W-1:0]     src_sq;
            logic                              dst_ready;
            logic [rgbhsv_pkg::HNUM_W-1:0]     hue_sub;
            logic [rgbhsv_pkg::SNUM_W-1:0]     sat_sub;
            rgbhsv_pkg::div_work_t             work_next;
            logic [rgbhsv_pkg::QUOT_W-1:0]     hq_next;
            logic [rgbhsv_pkg::QUOT_W-1:0]     sq_next;

            // Source of this stage: the front end or the previous stage
            if (k == 0) begin : g_first
                assign src_valid = in_valid;
                assign src_work  = in_work;
                assign src_hq    = '0;
                assign src_sq    = '0;
            end else begin : g_rest
                assign src_valid = valid_reg[k-1];
                assign src_work  = work_reg[k-1];
                assign src_hq    = hq_reg[k-1];
                assign src_sq    = sq_reg[k-1];
            end

            if (k == NSTG - 1) begin : g_last
                assign dst_ready = out_ready;
            end else begin : g_mid
                assign dst_ready = stage_ready[k+1];
            end

            assign stage_ready[k] = !valid_reg[k] || dst_ready;

            // Trial subtraction of the shifted divisors
            always_comb begin
                hue_sub   = {8'b0, src_work.hue_den} << SH;
                sat_sub   = {8'b0, src_work.sat_den} << SH;
                work_next = src_work;
                hq_next   = src_hq;
                sq_next   = src_sq;
                if (src_work.hue_rem >= hue_sub) begin
                    work_next.hue_rem = src_work.hue_rem - hue_sub;
                    hq_next[SH]       = 1'b1;
                end
                if (src_work.sat_rem >= sat_sub) begin
                    work_next.sat_rem = src_work.sat_rem - sat_sub;
                    sq_next[SH]       = 1'b1;
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[k] <= 1'b0;
                end else if (stage_ready[k]) begin
                    valid_reg[k] <= src_valid;
                end
                if (stage_ready[k] && src_valid) begin
                    work_reg[k] <= work_next;
                    hq_reg[k]   <= hq_next;
                    sq_reg[k]   <= sq_next;
                end
            end
        end
    endgenerate

    assign in_ready       = stage_ready[0];
    assign out_valid      = valid_reg[NSTG-1];
    assign out_hue        = hq_reg[NSTG-1];
    assign out_saturation = sq_reg[NSTG-1];
    assign out_brightness = work_reg[NSTG-1].brightness;

endmodule

`default_nettype wire

/* design/rgb_to_hsv_pixel_unit.sv */
// Top level of the RGB to HSV pixel converter.
//
//  channel | direction | ports                                  | handshake
//  --------+-----------+----------------------------------------+----------------
//  input   | in        | s_blue, s_green, s_red                 | s_valid/s_ready
//  result  | out       | m_hue, m_saturation, m_brightness      | m_valid/m_ready
//
// One pixel per cycle sustained while m_ready stays high; 3 front-end stages,
// then 8 divider stages, one quotient bit each.
// Every stage has its own valid bit and takes data when empty or draining, so
// bubbles collapse and a stalled result holds its stage while earlier stages fill.
// Synchronous active-low reset clears all valid bits; s_ready is low in reset.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_pixel_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_blue,
    input  wire logic [7:0] s_green,
    input  wire logic [7:0] s_red,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_hue,
    output logic [7:0]      m_saturation,
    output logic [7:0]      m_brightness
);

    logic                  front_ready;
    logic                  work_valid;
    logic                  work_ready;
    rgbhsv_pkg::div_work_t work;

    // No request is taken while reset is held
    assign s_ready = front_ready && aresetn;

    rgbhsv_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (front_ready),
        .in_blue   (s_blue),
        .in_green  (s_green),
        .in_red    (s_red),
        .out_valid (work_valid),
        .out_ready (work_ready),
        .out_work  (work)
    );

    rgbhsv_div u_div (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (work_valid),
        .in_ready       (work_ready),
        .in_work        (work),
        .out_valid      (m_valid),
        .out_ready      (m_ready),
        .out_hue        (m_hue),
        .out_saturation (m_saturation),
        .out_brightness (m_brightness)
    );

endmodule

`default_nettype wire

/* design/rgbhsv_checker.sv */
// Port-level checks of the converter and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rgbhsv_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_hue,
    input wire logic [7:0] m_saturation,
    input wire logic [7:0] m_brightness
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result request present right after reset");

    // A stalled result request holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hue) &&
        $stable(m_saturation) && $stable(m_brightness))
        else $error("stalled result request changed");

    // Hue never reaches 255
    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_hue != 8'hFF)
        else $error("hue out of range");

    // Zero saturation means a gray pixel, hence zero hue
    a_gray: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturation == 8'd0 |-> m_hue == 8'd0)
        else $error("gray pixel with nonzero hue");

    // Black pixel gives zero saturation
    a_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_brightness == 8'd0 |-> m_saturation == 8'd0)
        else $error("black pixel with nonzero saturation");

endmodule

bind rgb_to_hsv_pixel_unit rgbhsv_checker u_rgbhsv_checker (.*);

`default_nettype wire
